@@ sv/fbpa_pkg.sv @@
package fbpa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int RING_SLOTS = MAX_BLOCKS + 1;
  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = ((BLK_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((BLK_W + CNT_W + 7) / 8) * 8;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_TAKEN = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
  } fbpa_cmd_t;

endpackage

@@ sv/fbpa_ctrl.sv @@
module fbpa_ctrl import fbpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  output logic      m_axis_tvalid,
  input  logic      m_axis_tready,
  output fbpa_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid;
    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid || m_axis_tready) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;

endmodule

@@ sv/fbpa_dp.sv @@
module fbpa_dp import fbpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  fbpa_cmd_t             cmd,
  input  logic                  in_op,
  input  logic [BLK_W-1:0]      in_blk,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata,
  output logic [STATUS_W-1:0]   out_status,
  output logic [BLK_W-1:0]      out_granted,
  output logic [CNT_W-1:0]      out_free
);

  logic [BLK_W-1:0]      ring_mem [RING_SLOTS];
  logic [BLK_W-1:0]      ring_rdata;
  logic [RING_SLOTS-1:0] ring_valid;
  logic [MAX_BLOCKS-1:0] taken;

  logic [CNT_W-1:0] pool;
  logic [CNT_W-1:0] head;
  logic [CNT_W-1:0] tail;
  logic             op_q;
  logic [BLK_W-1:0] blk_q;

  logic [CNT_W-1:0]    cfg_clamped;
  logic [BLK_W-1:0]    entry;
  logic [CNT_W-1:0]    head_inc;
  logic [CNT_W-1:0]    tail_inc;
  logic [CNT_W-1:0]    head_next;
  logic [CNT_W-1:0]    tail_next;
  logic [STATUS_W-1:0] status_next;
  logic [BLK_W-1:0]    granted_next;
  logic                do_alloc;
  logic                do_release;
  logic [CNT_W:0]      wrap_sum;
  logic [CNT_W-1:0]    free_next;

  always_comb begin
    cfg_clamped = cfg_wdata;
    if (cfg_wdata == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_wdata > CNT_W'(MAX_BLOCKS)) begin
      cfg_clamped = CNT_W'(MAX_BLOCKS);
    end
  end

  // A ring entry that was not written since the last rebuild holds its own slot number.
  assign entry    = ring_valid[head] ? ring_rdata : head[BLK_W-1:0];
  assign head_inc = (head == pool) ? '0 : CNT_W'(head + CNT_W'(1));
  assign tail_inc = (tail == pool) ? '0 : CNT_W'(tail + CNT_W'(1));

  always_comb begin
    status_next  = STAT_OK;
    granted_next = '0;
    do_alloc     = 1'b0;
    do_release   = 1'b0;
    head_next    = head;
    tail_next    = tail;
    if (op_q == OP_ALLOC) begin
      if (head == tail) begin
        status_next = STAT_EMPTY;
      end else begin
        do_alloc     = 1'b1;
        granted_next = entry;
        head_next    = head_inc;
      end
    end else begin
      priority if ({1'b0, blk_q} >= pool) begin
        status_next = STAT_RANGE;
      end else if (!taken[blk_q]) begin
        status_next = STAT_NOT_TAKEN;
      end else if (tail_inc == head) begin
        status_next = STAT_FULL;
      end else begin
        do_release = 1'b1;
        tail_next  = tail_inc;
      end
    end
  end

  assign wrap_sum  = {1'b0, tail_next} + {1'b0, pool} + (CNT_W+1)'(1) - {1'b0, head_next};
  assign free_next = (tail_next >= head_next) ? CNT_W'(tail_next - head_next)
                                              : wrap_sum[CNT_W-1:0];

  always_ff @(posedge clk) begin
    ring_rdata <= ring_mem[head];
    if (cmd.exec && do_release) begin
      ring_mem[tail] <= blk_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool       <= CNT_W'(MAX_BLOCKS);
      head       <= '0;
      tail       <= CNT_W'(MAX_BLOCKS);
      ring_valid <= '0;
      taken      <= '0;
    end else if (cfg_we) begin
      pool       <= cfg_clamped;
      head       <= '0;
      tail       <= cfg_clamped;
      ring_valid <= '0;
      taken      <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      tail <= tail_next;
      if (do_alloc) begin
        taken[entry] <= 1'b1;
      end
      if (do_release) begin
        taken[blk_q]     <= 1'b0;
        ring_valid[tail] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_op;
      blk_q <= in_blk;
    end
    if (cmd.exec) begin
      out_status  <= status_next;
      out_granted <= granted_next;
      out_free    <= free_next;
    end
  end

endmodule

@@ sv/fixed_block_pool_allocator.sv @@
// Fixed block pool allocator. Each input beat is an allocate (tuser 0) or a release
// (tuser 1, block index in tdata) and yields one output beat with a status code, the
// granted block index and the number of free blocks left. An item is handled in a load
// step, which reads the free-index ring memory at the head pointer into a register, and
// then an execute step, which updates the pointers and marks and registers the result;
// execute waits while an earlier result is held, and no new item is taken before it.
// The result waits in an output register, so the next item is accepted while it is still
// held. Writing cfg_wdata sets the pool size (0 is taken as 1, values above 64 as 64) and
// makes every block free again in the same cycle; write it only while no item is in flight.
module fixed_block_pool_allocator import fbpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [5:0] block_index
  input  logic                  s_axis_tuser,   // [0] opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] granted_index, [12:6] free_blocks
  output logic [STATUS_W-1:0]   m_axis_tuser,   // [2:0] status
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata
);

  fbpa_cmd_t        cmd;
  logic [BLK_W-1:0] granted;
  logic [CNT_W-1:0] free_blocks;

  fbpa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd)
  );

  fbpa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_op       (s_axis_tuser),
    .in_blk      (s_axis_tdata[BLK_W-1:0]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_status  (m_axis_tuser),
    .out_granted (granted),
    .out_free    (free_blocks)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-BLK_W-CNT_W){1'b0}}, free_blocks, granted};

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is still being processed");

  a_grant_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != STAT_OK) |-> (granted == '0))
    else $error("nonzero granted index on a failed operation");

  a_free_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (free_blocks <= CNT_W'(MAX_BLOCKS)))
    else $error("free block count above pool maximum");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_EMPTY ||
                       m_axis_tuser == STAT_RANGE || m_axis_tuser == STAT_NOT_TAKEN ||
                       m_axis_tuser == STAT_FULL))
    else $error("undefined status code on output");
`endif

endmodule

@@ sim/fixed_block_pool_allocator_tb.sv @@
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 100;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    granted;
    logic [CNT_W-1:0]    free_cnt;
  } pool_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = OP_ALLOC;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  cfg_we = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata = '0;

  pool_result_t pending_results[$];
  int           err_count = 0;
  int           quiet_cycles = 0;
  int           src_idle_pct = 0;
  int           sink_stall_pct = 0;
  int           hold_len = 0;
  int           hold_left = 0;

  // Shadow of the allocator state.
  int           pool_size;
  logic [6:0]   idx_ring [RING_SLOTS];
  logic         in_use [MAX_BLOCKS];
  int           rd_ptr;
  int           wr_ptr;
  logic [31:0]  n_alloc;
  logic [31:0]  n_release;

  fixed_block_pool_allocator u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void rebuild_pool();
    for (int i = 0; i < RING_SLOTS; i++) begin
      idx_ring[i] = 7'(i);
    end
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      in_use[i] = 1'b0;
    end
    rd_ptr = 0;
    wr_ptr = pool_size;
  endfunction

  function automatic pool_result_t apply_pool_op(logic op, logic [BLK_W-1:0] blk);
    pool_result_t res;
    int           slots;
    int           nxt;
    logic [6:0]   g;
    res = '0;
    slots = pool_size + 1;
    if (op == OP_ALLOC) begin
      if (rd_ptr == wr_ptr) begin
        res.status = STAT_EMPTY;
      end else begin
        g = idx_ring[rd_ptr];
        rd_ptr = (rd_ptr + 1) % slots;
        n_alloc = n_alloc + 1;
        if (g < MAX_BLOCKS) in_use[g] = 1'b1;
        res.granted = g[BLK_W-1:0];
      end
    end else begin
      nxt = (wr_ptr + 1) % slots;
      if (blk >= pool_size) begin
        res.status = STAT_RANGE;
      end else if (!in_use[blk]) begin
        res.status = STAT_NOT_TAKEN;
      end else if (nxt == rd_ptr) begin
        res.status = STAT_FULL;
      end else begin
        idx_ring[wr_ptr] = {1'b0, blk};
        wr_ptr = nxt;
        n_release = n_release + 1;
        in_use[blk] = 1'b0;
      end
    end
    res.free_cnt = CNT_W'((wr_ptr + slots - rd_ptr) % slots);
    return res;
  endfunction

  function automatic int pick_taken_block();
    int taken[$];
    for (int i = 0; i < pool_size; i++) begin
      if (in_use[i]) taken.push_back(i);
    end
    if (taken.size() == 0) return -1;
    return taken[$urandom_range(taken.size() - 1)];
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_op(logic op, logic [BLK_W-1:0] blk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_W'(blk);
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(apply_pool_op(op, blk));
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_pool_size(logic [CNT_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    pool_size = (value < 1) ? 1 : (value > MAX_BLOCKS) ? MAX_BLOCKS : int'(value);
    rebuild_pool();
  endtask

  task automatic send_random_op(int alloc_pct);
    int r;
    int t;
    r = $urandom_range(99);
    if (r < 8) begin
      send_op(OP_RELEASE, BLK_W'($urandom_range(63)));
    end else if (r < 8 + alloc_pct) begin
      send_op(OP_ALLOC, BLK_W'($urandom_range(63)));
    end else begin
      t = pick_taken_block();
      if (t < 0) send_op(OP_ALLOC, BLK_W'($urandom_range(63)));
      else send_op(OP_RELEASE, BLK_W'(t));
    end
  endtask

  task automatic test_reset_state();
    send_op(OP_RELEASE, 6'd63);
    send_op(OP_ALLOC, 6'd63);
    send_op(OP_RELEASE, 6'd0);
    send_op(OP_ALLOC, 6'd0);
  endtask

  task automatic test_size_limits();
    write_pool_size(7'd0);
    send_op(OP_ALLOC, 6'd0);
    send_op(OP_ALLOC, 6'd0);
    send_op(OP_RELEASE, 6'd1);
    send_op(OP_RELEASE, 6'd63);
    send_op(OP_RELEASE, 6'd0);
    send_op(OP_RELEASE, 6'd0);
    write_pool_size(7'd127);
    send_op(OP_RELEASE, 6'd63);
  endtask

  task automatic test_ring_wrap();
    write_pool_size(7'd2);
    send_op(OP_ALLOC, 6'd0);
    send_op(OP_ALLOC, 6'd0);
    send_op(OP_ALLOC, 6'd0);
    send_op(OP_RELEASE, 6'd1);
    send_op(OP_ALLOC, 6'd0);
    send_op(OP_RELEASE, 6'd0);
    send_op(OP_RELEASE, 6'd1);
  endtask

  task automatic test_resize_while_taken();
    write_pool_size(7'd4);
    send_op(OP_ALLOC, 6'd0);
    send_op(OP_ALLOC, 6'd0);
    write_pool_size(7'd4);
    send_op(OP_RELEASE, 6'd0);
    send_op(OP_ALLOC, 6'd0);
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_pool_size(7'd64);
    hold_len = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) begin
      send_random_op(60);
    end
    drain();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
    int sent;
    int seg;
    int bias;
    int sel;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(9);
      case (sel)
        0: write_pool_size(7'd0);
        1: write_pool_size(CNT_W'($urandom_range(65, 127)));
        2: write_pool_size(7'd64);
        default: write_pool_size(CNT_W'($urandom_range(1, 8)));
      endcase
      seg = $urandom_range(20, 40) + 3 * pool_size;
      bias = $urandom_range(25, 75);
      for (int i = 0; i < seg; i++) begin
        if (i == seg / 2) bias = 100 - bias;
        send_random_op(bias);
      end
      sent += seg;
    end
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    pool_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d tdata 0x%0h", m_axis_tuser, m_axis_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          err_count++;
        end
        if (m_axis_tdata[5:0] !== want.granted) begin
          $error("granted_index: expected %0d, got %0d", want.granted, m_axis_tdata[5:0]);
          err_count++;
        end
        if (m_axis_tdata[12:6] !== want.free_cnt) begin
          $error("free_blocks: expected %0d, got %0d", want.free_cnt, m_axis_tdata[12:6]);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pool_size = MAX_BLOCKS;
    n_alloc   = '0;
    n_release = '0;
    rebuild_pool();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_size_limits();
    test_ring_wrap();
    test_resize_while_taken();
    test_backpressure();
    test_random_traffic(0, 0, 450);
    test_random_traffic(52, 0, 450);
    test_random_traffic(0, 52, 450);
    test_random_traffic(37, 37, 450);

    drain();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/fbpa_pkg.sv
sv/fbpa_ctrl.sv
sv/fbpa_dp.sv
sv/fixed_block_pool_allocator.sv
sim/fixed_block_pool_allocator_tb.sv
